// ===== design/sign_region_color_classifier_core_defines.svh =====
// Assertion macros shared by the sign region color classifier modules.
`ifndef SIGN_REGION_COLOR_CLASSIFIER_CORE_DEFINES_SVH
`define SIGN_REGION_COLOR_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRCC_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srcc assertion failed");

// Next-cycle implication, checked outside reset.
`define SRCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srcc assertion failed");

`endif

// ===== design/srcc_pkg.sv =====
// Types, constants and helpers of the sign region color classifier.
`default_nettype none

package srcc_pkg;

    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 128;

    localparam int CHAN_W     = 8;
    localparam int TALLY_W    = 16;
    localparam int WSUM_W     = 24;
    localparam int PCT_W      = 7;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_COLS_W = 9;
    localparam int CFG_ROWS_W = 8;
    localparam int DIV_W      = WSUM_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [TALLY_W-1:0]    TALLY_MAX  = 16'hFFFF;
    localparam logic [WSUM_W-1:0]     WSUM_MAX   = 24'hFFFFFF;
    localparam logic [CFG_COLS_W-1:0] RESET_COLS = 9'd240;
    localparam logic [CFG_ROWS_W-1:0] RESET_ROWS = 8'd120;

    localparam logic [CHAN_W-1:0] BLACK_MAX   = 8'd100;
    localparam logic [CHAN_W-1:0] GREY_DIFF   = 8'd25;
    localparam logic [CHAN_W-1:0] WHITE_MIN   = 8'd90;
    localparam logic [CHAN_W:0]   BLUE_MARGIN = 9'd10;
    localparam int                EDGE_COLS   = 4;

    // floor(x/10) = (x * RECIP10) >> DIV10_SHIFT for every 16-bit x
    localparam logic [15:0] RECIP10     = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
    localparam logic [PCT_W-1:0] STOP_RED   = 7'd40;
    localparam logic [PCT_W-1:0] PED_BLACK  = 7'd5;
    localparam logic [PCT_W-1:0] PED_BLUE   = 7'd40;
    localparam logic [PCT_W-1:0] ARROW_BLUE = 7'd60;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_COLS = 1'b0,
        CFG_REGION_ROWS = 1'b1
    } t_cfg_index;

    typedef enum logic [CODE_W-1:0] {
        SIGN_NONE       = 3'd0,
        SIGN_FORWARD    = 3'd1,
        SIGN_RIGHT      = 3'd2,
        SIGN_LEFT       = 3'd3,
        SIGN_STOP       = 3'd4,
        SIGN_PEDESTRIAN = 3'd5
    } t_sign_code;

    typedef struct packed {
        logic [TALLY_W-1:0] red;
        logic [TALLY_W-1:0] blue;
        logic [TALLY_W-1:0] black;
        logic [TALLY_W-1:0] white;
        logic [WSUM_W-1:0]  wsum;
    } t_tallies;

    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ===== design/srcc_pixel_if.sv =====
// Pixel word channel: valid, ready and one BGR pixel with its end-of-region flag.
`default_nettype none

interface srcc_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [srcc_pkg::CHAN_W-1:0] blue_level;
    logic [srcc_pkg::CHAN_W-1:0] green_level;
    logic [srcc_pkg::CHAN_W-1:0] red_level;
    logic                        last_pixel;

    modport source (output valid, blue_level, green_level, red_level, last_pixel,
                    input ready);
    modport sink (input valid, blue_level, green_level, red_level, last_pixel,
                  output ready);
endinterface

`default_nettype wire

// ===== design/srcc_result_if.sv =====
// Result word channel: valid, ready, sign code and class percentages.
`default_nettype none

interface srcc_result_if;
    logic                        valid;
    logic                        ready;
    logic [srcc_pkg::CODE_W-1:0] sign_code;
    logic [srcc_pkg::PCT_W-1:0]  red_percent;
    logic [srcc_pkg::PCT_W-1:0]  blue_percent;
    logic [srcc_pkg::PCT_W-1:0]  black_percent;

    modport source (output valid, sign_code, red_percent, blue_percent, black_percent,
                    input ready);
    modport sink (input valid, sign_code, red_percent, blue_percent, black_percent,
                  output ready);
endinterface

`default_nettype wire

// ===== design/sign_region_color_classifier_core.sv =====
// Sign region color classifier: top level joining front end, summary queue and back end.
//
// Usage:
//   i_pix carries one BGR pixel word per cycle in raster order; last_pixel marks
//   the final pixel of a region. o_res carries one word per region: sign code
//   and the red, blue and black percentages. The configuration port writes
//   region_cols (index 0) and region_rows (index 1); the user must do so only while the
//   block is idle, which the block itself does not enforce.
// Throughput: one pixel per cycle while i_pix.ready is high. A region summary passes the back-end
//   divider loop (a load, one quotient step per dividend bit, a decide); regions that take as long
//   to stream in as that loop do not stall, shorter ones fill the two-entry summary queue and then
//   i_pix.ready drops. Result path: the summary is queued when the last pixel is taken; the back
//   end pops it, divides, and writes the result word into the output register once that is free.
// Reset: tallies, positions, queue and output valid clear; region_cols returns
//   to 240 and region_rows to 120.
// Receiver stall: the result word holds in the output register; the back end
//   waits, the queue fills, and pixel intake stops once it is full.
`default_nettype none

module sign_region_color_classifier_core #(
    parameter int MAX_COLS = srcc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = srcc_pkg::DEF_MAX_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    srcc_pixel_if.sink                      i_pix,
    srcc_result_if.source                   o_res,
    input  logic                            i_cfg_we,
    input  logic [srcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srcc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int QW = CW + RW + $bits(srcc_pkg::t_tallies);

    logic          w_push, w_full, w_pop, w_empty;
    logic [QW-1:0] w_push_data, w_pop_data;

    srcc_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full)
    );

    srcc_fifo #(.WIDTH(QW), .DEPTH(srcc_pkg::QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_data)
    );

    srcc_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_data  (w_pop_data),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== design/srcc_front.sv =====
// Front end: configuration, per-pixel classification, tallies and region summary push.
`default_nettype none

module srcc_front #(
    parameter int MAX_COLS = srcc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = srcc_pkg::DEF_MAX_ROWS,
    localparam int CW = $clog2(MAX_COLS + 1),
    localparam int RW = $clog2(MAX_ROWS + 1),
    localparam int QW = CW + RW + $bits(srcc_pkg::t_tallies)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    srcc_pixel_if.sink                     i_pix,
    input  logic                           i_cfg_we,
    input  logic [srcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_push,
    output logic [QW-1:0]                  o_push_data,
    input  logic                           i_full
);

    localparam int CPW = $clog2(MAX_COLS);
    localparam int RPW = $clog2(MAX_ROWS);
    localparam int SPW = RW + 3 + 16;

    logic [srcc_pkg::CFG_COLS_W-1:0] r_cfg_cols;
    logic [srcc_pkg::CFG_ROWS_W-1:0] r_cfg_rows;
    logic [CPW-1:0]                  r_col, n_col;
    logic [RPW-1:0]                  r_row, n_row;
    srcc_pkg::t_tallies              r_tl, n_tl;

    logic [CW-1:0]     w_cols;
    logic [RW-1:0]     w_rows;
    logic [RW+2:0]     w_rows7;
    logic [SPW-1:0]    w_scan_prod;
    logic [RW-1:0]     w_scan_row;
    logic [CPW-1:0]    w_col;
    logic [RPW-1:0]    w_row;
    logic [CW:0]       w_col_inc;
    logic [RW:0]       w_row_inc;
    logic              w_accept;
    logic              w_black, w_red, w_blue, w_white;
    logic [srcc_pkg::CHAN_W-1:0] w_b, w_g, w_r, w_gr_max;
    logic [11:0]       w_red_lhs, w_red_rhs;
    logic [srcc_pkg::WSUM_W:0] w_wsum_ext;

    assign w_b = i_pix.blue_level;
    assign w_g = i_pix.green_level;
    assign w_r = i_pix.red_level;

    assign i_pix.ready = !i_full;
    assign w_accept    = i_pix.valid && i_pix.ready;

    always_comb begin
        if (r_cfg_cols == '0) begin
            w_cols = CW'(1);
        end else if (32'(r_cfg_cols) > MAX_COLS) begin
            w_cols = CW'(MAX_COLS);
        end else begin
            w_cols = CW'(r_cfg_cols);
        end
        if (r_cfg_rows == '0) begin
            w_rows = RW'(1);
        end else if (32'(r_cfg_rows) > MAX_ROWS) begin
            w_rows = RW'(MAX_ROWS);
        end else begin
            w_rows = RW'(r_cfg_rows);
        end
    end

    assign w_rows7     = (RW + 3)'(w_rows) * (RW + 3)'(7);
    assign w_scan_prod = SPW'(w_rows7) * SPW'(srcc_pkg::RECIP10);
    assign w_scan_row  = RW'(w_scan_prod >> srcc_pkg::DIV10_SHIFT);

    assign w_col = ((CW + 1)'(r_col) >= (CW + 1)'(w_cols)) ? '0 : r_col;
    assign w_row = ((RW + 1)'(r_row) >= (RW + 1)'(w_rows)) ? '0 : r_row;

    assign w_gr_max  = (w_g > w_r) ? w_g : w_r;
    assign w_red_lhs = 12'(w_r) * 12'd10;
    assign w_red_rhs = (12'(w_g) + 12'(w_b)) * 12'd7;

    assign w_black = (w_b <= srcc_pkg::BLACK_MAX) &&
                     (srcc_pkg::absdiff(w_b, w_g) < srcc_pkg::GREY_DIFF) &&
                     (srcc_pkg::absdiff(w_b, w_r) < srcc_pkg::GREY_DIFF) &&
                     (srcc_pkg::absdiff(w_r, w_g) < srcc_pkg::GREY_DIFF);
    assign w_red   = w_red_lhs > w_red_rhs;
    assign w_blue  = {1'b0, w_b} > ({1'b0, w_gr_max} + srcc_pkg::BLUE_MARGIN);
    assign w_white = (RW'(w_row) == w_scan_row) &&
                     ((CW + 1)'(w_col) >= (CW + 1)'(srcc_pkg::EDGE_COLS)) &&
                     (((CW + 1)'(w_col) + (CW + 1)'(srcc_pkg::EDGE_COLS)) <
                      (CW + 1)'(w_cols)) &&
                     (w_r > srcc_pkg::WHITE_MIN) && (w_g > srcc_pkg::WHITE_MIN) &&
                     (w_b > srcc_pkg::WHITE_MIN);

    assign w_wsum_ext = (srcc_pkg::WSUM_W + 1)'(r_tl.wsum) + (srcc_pkg::WSUM_W + 1)'(w_col);

    always_comb begin
        n_tl = r_tl;
        if (w_black && (r_tl.black != srcc_pkg::TALLY_MAX)) begin
            n_tl.black = r_tl.black + 1'b1;
        end
        if (w_red && (r_tl.red != srcc_pkg::TALLY_MAX)) begin
            n_tl.red = r_tl.red + 1'b1;
        end
        if (w_blue && (r_tl.blue != srcc_pkg::TALLY_MAX)) begin
            n_tl.blue = r_tl.blue + 1'b1;
        end
        if (w_white) begin
            if (r_tl.white != srcc_pkg::TALLY_MAX) begin
                n_tl.white = r_tl.white + 1'b1;
            end
            if (w_wsum_ext > (srcc_pkg::WSUM_W + 1)'(srcc_pkg::WSUM_MAX)) begin
                n_tl.wsum = srcc_pkg::WSUM_MAX;
            end else begin
                n_tl.wsum = w_wsum_ext[srcc_pkg::WSUM_W-1:0];
            end
        end
    end

    always_comb begin
        w_col_inc = (CW + 1)'(w_col) + (CW + 1)'(1);
        w_row_inc = (RW + 1)'(w_row) + (RW + 1)'(1);
        n_col     = CPW'(w_col_inc);
        n_row     = w_row;
        if (w_col_inc >= (CW + 1)'(w_cols)) begin
            n_col = '0;
            n_row = (w_row_inc >= (RW + 1)'(w_rows)) ? '0 : RPW'(w_row_inc);
        end
    end

    assign o_push      = w_accept && i_pix.last_pixel;
    assign o_push_data = {w_cols, w_rows, n_tl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= srcc_pkg::RESET_COLS;
            r_cfg_rows <= srcc_pkg::RESET_ROWS;
            r_col      <= '0;
            r_row      <= '0;
            r_tl       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (srcc_pkg::t_cfg_index'(i_cfg_index))
                    srcc_pkg::CFG_REGION_COLS: begin
                        r_cfg_cols <= i_cfg_data[srcc_pkg::CFG_COLS_W-1:0];
                    end
                    srcc_pkg::CFG_REGION_ROWS: begin
                        r_cfg_rows <= i_cfg_data[srcc_pkg::CFG_ROWS_W-1:0];
                    end
                endcase
            end
            if (w_accept) begin
                if (i_pix.last_pixel) begin
                    r_col <= '0;
                    r_row <= '0;
                    r_tl  <= '0;
                end else begin
                    r_col <= n_col;
                    r_row <= n_row;
                    r_tl  <= n_tl;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/srcc_fifo.sv =====
// Short queue of region summaries between the front and back ends.
`default_nettype none
`include "sign_region_color_classifier_core_defines.svh"

module srcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = srcc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_count;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SRCC_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push, (r_count != NW'(DEPTH)))
    `SRCC_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop, (r_count != '0))

endmodule

`default_nettype wire

// ===== design/srcc_div.sv =====
// Radix-2 restoring divider lane, one quotient bit per step.
`default_nettype none

module srcc_div #(
    parameter int NW = srcc_pkg::DIV_W,
    parameter int DW = srcc_pkg::TALLY_W
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic          i_step,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [NW-1:0] o_quot
);

    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_shift = {r_rem, r_quo[NW-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign o_quot  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (i_step) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

// ===== design/srcc_back.sv =====
// Back end: percentage and stem-column division, sign decision, result register.
`default_nettype none
`include "sign_region_color_classifier_core_defines.svh"

module srcc_back #(
    parameter int MAX_COLS = srcc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = srcc_pkg::DEF_MAX_ROWS,
    localparam int CW = $clog2(MAX_COLS + 1),
    localparam int RW = $clog2(MAX_ROWS + 1),
    localparam int QW = CW + RW + $bits(srcc_pkg::t_tallies)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  logic [QW-1:0] i_data,
    output logic          o_pop,
    srcc_result_if.source o_res
);

    localparam int TLW   = $bits(srcc_pkg::t_tallies);
    localparam int TW    = CW + RW;
    localparam int NW    = srcc_pkg::DIV_W;
    localparam int CNT_W = $clog2(NW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DIV    = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CW-1:0]    r_cols;
    logic             r_white_nz;
    logic             w_load, w_step, w_write;

    logic                         r_ovalid;
    logic [srcc_pkg::CODE_W-1:0]  r_code;
    logic [srcc_pkg::PCT_W-1:0]   r_red_pct, r_blue_pct, r_black_pct;

    logic [CW-1:0]      w_in_cols;
    logic [RW-1:0]      w_in_rows;
    srcc_pkg::t_tallies w_in_tl;
    logic [TW-1:0]      w_total;
    logic [NW-1:0]      q_red, q_blue, q_black, q_avg;
    logic [srcc_pkg::PCT_W-1:0] w_rp, w_bp, w_kp;
    logic [NW+3:0]      w_c10, w_six, w_four;
    srcc_pkg::t_sign_code w_code;

    function automatic logic [srcc_pkg::PCT_W-1:0] sat_pct(input logic [NW-1:0] q);
        return (q > NW'(srcc_pkg::PCT_FULL)) ? srcc_pkg::PCT_FULL
                                             : q[srcc_pkg::PCT_W-1:0];
    endfunction

    assign w_in_cols = i_data[QW-1 -: CW];
    assign w_in_rows = i_data[TLW +: RW];
    assign w_in_tl   = srcc_pkg::t_tallies'(i_data[TLW-1:0]);
    assign w_total   = TW'(w_in_cols) * TW'(w_in_rows);

    srcc_div #(.NW(NW), .DW(TW)) u_div_red (
        .i_clk(i_clk), .i_load(w_load), .i_step(w_step),
        .i_dividend(NW'(w_in_tl.red) * NW'(srcc_pkg::PCT_FULL)),
        .i_divisor(w_total), .o_quot(q_red)
    );

    srcc_div #(.NW(NW), .DW(TW)) u_div_blue (
        .i_clk(i_clk), .i_load(w_load), .i_step(w_step),
        .i_dividend(NW'(w_in_tl.blue) * NW'(srcc_pkg::PCT_FULL)),
        .i_divisor(w_total), .o_quot(q_blue)
    );

    srcc_div #(.NW(NW), .DW(TW)) u_div_black (
        .i_clk(i_clk), .i_load(w_load), .i_step(w_step),
        .i_dividend(NW'(w_in_tl.black) * NW'(srcc_pkg::PCT_FULL)),
        .i_divisor(w_total), .o_quot(q_black)
    );

    srcc_div #(.NW(NW), .DW(srcc_pkg::TALLY_W)) u_div_avg (
        .i_clk(i_clk), .i_load(w_load), .i_step(w_step),
        .i_dividend(w_in_tl.wsum), .i_divisor(w_in_tl.white), .o_quot(q_avg)
    );

    assign w_rp   = sat_pct(q_red);
    assign w_bp   = sat_pct(q_blue);
    assign w_kp   = sat_pct(q_black);
    assign w_c10  = ((NW + 4)'(q_avg) << 3) + ((NW + 4)'(q_avg) << 1);
    assign w_six  = (NW + 4)'(r_cols) * (NW + 4)'(6);
    assign w_four = (NW + 4)'(r_cols) * (NW + 4)'(4);

    always_comb begin
        priority if (w_rp > srcc_pkg::STOP_RED) begin
            w_code = srcc_pkg::SIGN_STOP;
        end else if ((w_kp > srcc_pkg::PED_BLACK) && (w_bp > srcc_pkg::PED_BLUE)) begin
            w_code = srcc_pkg::SIGN_PEDESTRIAN;
        end else if ((w_bp > srcc_pkg::ARROW_BLUE) && r_white_nz) begin
            if (w_c10 >= w_six) begin
                w_code = srcc_pkg::SIGN_LEFT;
            end else if (w_c10 >= w_four) begin
                w_code = srcc_pkg::SIGN_FORWARD;
            end else begin
                w_code = srcc_pkg::SIGN_RIGHT;
            end
        end else begin
            w_code = srcc_pkg::SIGN_NONE;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        w_step  = 1'b0;
        w_write = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    w_load  = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                w_step = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!r_ovalid || o_res.ready) begin
                    w_write = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cols     <= w_in_cols;
            r_white_nz <= (w_in_tl.white != '0);
        end
        if (w_write) begin
            r_code      <= w_code;
            r_red_pct   <= w_rp;
            r_blue_pct  <= w_bp;
            r_black_pct <= w_kp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_write) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.sign_code     = r_code;
    assign o_res.red_percent   = r_red_pct;
    assign o_res.blue_percent  = r_blue_pct;
    assign o_res.black_percent = r_black_pct;

    `SRCC_ASSERT(a_pct_range, i_clk, i_rst_n, r_ovalid, ((r_red_pct <= srcc_pkg::PCT_FULL) && (r_blue_pct <= srcc_pkg::PCT_FULL) && (r_black_pct <= srcc_pkg::PCT_FULL)))
    `SRCC_ASSERT_NEXT(a_div_len, i_clk, i_rst_n, ((r_state == S_DIV) && (r_cnt == CNT_LAST)), (r_state == S_DECIDE))

endmodule

`default_nettype wire
